/* hw/rtl/mbrot_pkg.sv */
`timescale 1ns / 1ps
// mbrot_pkg: types, constants and helpers shared by the escape-time pixel evaluator
// no dependencies; imported by every module under hw/rtl

package mbrot_pkg;

	localparam int COORD_WIDTH = 12;
	localparam int FRAC_BITS = 28;
	localparam int ITER_WIDTH = 16;
	localparam int VAL_WIDTH = 32;
	localparam int STEP_WIDTH = 31;
	localparam int PROD_WIDTH = 2 * VAL_WIDTH;
	localparam int CFG_IDX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH = 32;
	localparam int COLOUR_WIDTH = 8;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_ORIGIN_REAL = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_ORIGIN_IMAG = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_STEP_REAL = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_STEP_IMAG = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_ITER = 3'd4;

	// reset values, Q4.28
	localparam logic signed [VAL_WIDTH-1:0] ORIGIN_REAL_RST = -32'sd563714458;
	localparam logic signed [VAL_WIDTH-1:0] ORIGIN_IMAG_RST = -32'sd322122547;
	localparam logic [STEP_WIDTH-1:0] STEP_REAL_RST = 31'd1132462;
	localparam logic [STEP_WIDTH-1:0] STEP_IMAG_RST = 31'd1342177;
	localparam logic [ITER_WIDTH-1:0] MAX_ITER_RST = 16'd500;

	// |z|^2 >= 4 in Q8.56
	localparam logic [PROD_WIDTH-1:0] ESC_LIMIT = 64'd4 << (2 * FRAC_BITS);

	localparam logic signed [VAL_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [COORD_WIDTH-1:0] pixel_x;
		logic [COORD_WIDTH-1:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic [COORD_WIDTH-1:0] out_x;
		logic [COORD_WIDTH-1:0] out_y;
		logic inside_res;
		logic [ITER_WIDTH-1:0] iteration_count;
		logic [COLOUR_WIDTH-1:0] red;
		logic [COLOUR_WIDTH-1:0] green;
		logic [COLOUR_WIDTH-1:0] blue;
	} result_t;

	typedef struct packed {
		logic signed [VAL_WIDTH-1:0] origin_real;
		logic signed [VAL_WIDTH-1:0] origin_imag;
		logic [STEP_WIDTH-1:0] step_real;
		logic [STEP_WIDTH-1:0] step_imag;
		logic [ITER_WIDTH-1:0] max_iterations;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_CR,
		ST_MUL_CI,
		ST_MUL_RR,
		ST_MUL_II,
		ST_MUL_RI,
		ST_UPDATE
	} seq_state_t;

	function automatic logic signed [PROD_WIDTH-1:0] sext_val(
		input logic signed [VAL_WIDTH-1:0] v
	);
		return $signed({{(PROD_WIDTH-VAL_WIDTH){v[VAL_WIDTH-1]}}, v});
	endfunction

	function automatic logic signed [VAL_WIDTH-1:0] sat_val(
		input logic signed [PROD_WIDTH-1:0] v
	);
		logic [PROD_WIDTH-VAL_WIDTH:0] top_bits;
		top_bits = v[PROD_WIDTH-1:VAL_WIDTH-1];
		if (top_bits == '0 || top_bits == '1) begin
			return $signed(v[VAL_WIDTH-1:0]);
		end else if (v[PROD_WIDTH-1]) begin
			return VAL_MIN;
		end else begin
			return VAL_MAX;
		end
	endfunction

endpackage

/* hw/rtl/mandelbrot_escape_time_pixel_top.sv */
`timescale 1ns / 1ps
// mandelbrot escape-time evaluator, one pixel per item, signed Q4.28 arithmetic
// a new item is taken only while idle; busy is high for the whole run
// each iteration takes three products on the single shared 32x32 multiplier plus one update
// reset clears the sequencer and loads the default window; results cannot be stalled
// depends on mbrot_pkg, mbrot_cfg_regs, mbrot_mul, mbrot_seq

module mandelbrot_escape_time_pixel_top (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  mbrot_pkg::pixel_t pixel,
	output logic done,
	output mbrot_pkg::result_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [mbrot_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [mbrot_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
	import mbrot_pkg::*;

	cfg_t cfg;
	logic signed [VAL_WIDTH-1:0] op_a, op_b;
	logic signed [PROD_WIDTH-1:0] prod;

	mbrot_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	mbrot_mul u_mul (
		.clk(clk),
		.op_a(op_a),
		.op_b(op_b),
		.prod(prod)
	);

	mbrot_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel(pixel),
		.cfg(cfg),
		.op_a(op_a),
		.op_b(op_b),
		.prod(prod),
		.done(done),
		.result(result)
	);

endmodule

/* hw/rtl/mbrot_cfg_regs.sv */
`timescale 1ns / 1ps
// mbrot_cfg_regs: window origin, step and iteration limit registers
// depends on mbrot_pkg

module mbrot_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [mbrot_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [mbrot_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
	output mbrot_pkg::cfg_t cfg
);
	import mbrot_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_real <= ORIGIN_REAL_RST;
			cfg_q.origin_imag <= ORIGIN_IMAG_RST;
			cfg_q.step_real <= STEP_REAL_RST;
			cfg_q.step_imag <= STEP_IMAG_RST;
			cfg_q.max_iterations <= MAX_ITER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ORIGIN_REAL: cfg_q.origin_real <= $signed(cfg_data[VAL_WIDTH-1:0]);
				CFG_ORIGIN_IMAG: cfg_q.origin_imag <= $signed(cfg_data[VAL_WIDTH-1:0]);
				CFG_STEP_REAL: cfg_q.step_real <= cfg_data[STEP_WIDTH-1:0];
				CFG_STEP_IMAG: cfg_q.step_imag <= cfg_data[STEP_WIDTH-1:0];
				CFG_MAX_ITER: cfg_q.max_iterations <= cfg_data[ITER_WIDTH-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* hw/rtl/mbrot_mul.sv */
`timescale 1ns / 1ps
// mbrot_mul: shared signed 32x32 multiplier with registered 64-bit product
// depends on mbrot_pkg

module mbrot_mul (
	input  logic clk,
	input  logic signed [mbrot_pkg::VAL_WIDTH-1:0] op_a,
	input  logic signed [mbrot_pkg::VAL_WIDTH-1:0] op_b,
	output logic signed [mbrot_pkg::PROD_WIDTH-1:0] prod
);
	import mbrot_pkg::*;

	logic signed [PROD_WIDTH-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= sext_val(op_a) * sext_val(op_b);
	end

	assign prod = prod_q;

endmodule

/* hw/rtl/mbrot_seq.sv */
`timescale 1ns / 1ps
// mbrot_seq: sequencer and iterate registers around the shared multiplier
// depends on mbrot_pkg; drives mbrot_mul operands, reads its product

module mbrot_seq (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  mbrot_pkg::pixel_t pixel,
	input  mbrot_pkg::cfg_t cfg,
	output logic signed [mbrot_pkg::VAL_WIDTH-1:0] op_a,
	output logic signed [mbrot_pkg::VAL_WIDTH-1:0] op_b,
	input  logic signed [mbrot_pkg::PROD_WIDTH-1:0] prod,
	output logic done,
	output mbrot_pkg::result_t result
);
	import mbrot_pkg::*;

	seq_state_t state_q, state_d;
	pixel_t pixel_q;
	logic signed [VAL_WIDTH-1:0] zr_q, zi_q, cr_q, ci_q;
	logic signed [PROD_WIDTH-1:0] sqr_q, diff_q;
	logic [ITER_WIDTH-1:0] count_q;
	logic done_q;
	result_t res_q;

	logic [PROD_WIDTH-1:0] mag_sum;
	logic finish;
	logic in_set;

	assign mag_sum = $unsigned(sqr_q) + $unsigned(prod);
	assign finish = (count_q != '0)
		&& ((mag_sum >= ESC_LIMIT) || (count_q >= cfg.max_iterations));
	assign in_set = (count_q == cfg.max_iterations);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_MUL_CR;
			ST_MUL_CR: state_d = ST_MUL_CI;
			ST_MUL_CI: state_d = ST_MUL_RR;
			ST_MUL_RR: state_d = ST_MUL_II;
			ST_MUL_II: state_d = ST_MUL_RI;
			ST_MUL_RI: state_d = finish ? ST_IDLE : ST_UPDATE;
			ST_UPDATE: state_d = ST_MUL_RR;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: multiplier operands and handshake
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			ST_MUL_CR: begin
				op_a = $signed({{(VAL_WIDTH-COORD_WIDTH){1'b0}}, pixel_q.pixel_x});
				op_b = $signed({1'b0, cfg.step_real});
			end
			ST_MUL_CI: begin
				op_a = $signed({{(VAL_WIDTH-COORD_WIDTH){1'b0}}, pixel_q.pixel_y});
				op_b = $signed({1'b0, cfg.step_imag});
			end
			ST_MUL_RR: begin
				op_a = zr_q;
				op_b = zr_q;
			end
			ST_MUL_II: begin
				op_a = zi_q;
				op_b = zi_q;
			end
			ST_MUL_RI: begin
				op_a = zr_q;
				op_b = zi_q;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == ST_MUL_RI) && finish;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					pixel_q <= pixel;
					zr_q <= '0;
					zi_q <= '0;
					count_q <= '0;
				end
			end
			ST_MUL_CI: cr_q <= sat_val(sext_val(cfg.origin_real) + prod);
			ST_MUL_RR: begin
				// product still holds y*step on the first pass
				if (count_q == '0) begin
					ci_q <= sat_val(sext_val(cfg.origin_imag) + prod);
				end
			end
			ST_MUL_II: sqr_q <= prod;
			ST_MUL_RI: begin
				diff_q <= sqr_q - prod;
				if (finish) begin
					res_q.out_x <= pixel_q.pixel_x;
					res_q.out_y <= pixel_q.pixel_y;
					res_q.inside_res <= in_set;
					res_q.iteration_count <= count_q;
					res_q.red <= in_set ? pixel_q.pixel_x[COLOUR_WIDTH-1:0] : '0;
					res_q.green <= in_set ? pixel_q.pixel_y[COLOUR_WIDTH-1:0] : '0;
					res_q.blue <= in_set ? '0 : count_q[COLOUR_WIDTH-1:0];
				end
			end
			ST_UPDATE: begin
				zr_q <= sat_val((diff_q >>> FRAC_BITS) + sext_val(cr_q));
				zi_q <= sat_val((prod >>> (FRAC_BITS - 1)) + sext_val(ci_q));
				count_q <= count_q + 1'b1;
			end
			default: ;
		endcase
	end

	a_done_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == ST_MUL_RI)
		else $error("result strobe without a termination check");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> res_q.iteration_count != '0)
		else $error("result with zero iterations");

	a_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && count_q != '0) |-> count_q < cfg.max_iterations)
		else $error("iterating past the limit");

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_MUL_CR && busy && !done_q))
		else $error("accepted item did not start the sequence");

endmodule

/* tb/sv/tb_mandelbrot_escape_time_pixel_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for the escape-time pixel evaluator: directed and random windows,
// each result checked against an in-bench fixed-point predictor of the iteration
// depends on mbrot_pkg and mandelbrot_escape_time_pixel_top

module tb_mandelbrot_escape_time_pixel_top;

	import mbrot_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT = 2_500_000;
	localparam int MAX_REPORTS = 200;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 150;
	localparam logic [STEP_WIDTH-1:0] STEP_MAX = '1;
	localparam longint Q_MAX = longint'(VAL_MAX);
	localparam longint Q_MIN = longint'(VAL_MIN);

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	pixel_t pixel;
	logic done;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0] cfg_data;

	// window as the block should currently hold it
	int win_origin_re;
	int win_origin_im;
	bit [STEP_WIDTH-1:0] win_step_re;
	bit [STEP_WIDTH-1:0] win_step_im;
	bit [ITER_WIDTH-1:0] iter_limit;

	result_t pending_pixels[$];
	int mismatches = 0;
	int cycles = 0;

	mandelbrot_escape_time_pixel_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel(pixel),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic longint clamp_q428(input longint v);
		if (v > Q_MAX) begin
			return Q_MAX;
		end else if (v < Q_MIN) begin
			return Q_MIN;
		end
		return v;
	endfunction

	function automatic result_t escape_time(input pixel_t p);
		longint px, py, sre, sim, c_re, c_im, z_re, z_im, n_re, n_im;
		bit [PROD_WIDTH-1:0] sq_re, sq_im;
		bit [ITER_WIDTH-1:0] n;
		bit escaped;
		bit in_set;
		result_t r;
		px = p.pixel_x;
		py = p.pixel_y;
		sre = win_step_re;
		sim = win_step_im;
		c_re = clamp_q428(longint'(win_origin_re) + px * sre);
		c_im = clamp_q428(longint'(win_origin_im) + py * sim);
		z_re = 0;
		z_im = 0;
		n = '0;
		do begin
			n_re = clamp_q428(((z_re * z_re - z_im * z_im) >>> FRAC_BITS) + c_re);
			n_im = clamp_q428(((z_re * z_im) >>> (FRAC_BITS - 1)) + c_im);
			z_re = n_re;
			z_im = n_im;
			n = n + 1'b1;
			sq_re = z_re * z_re;
			sq_im = z_im * z_im;
			escaped = (sq_re + sq_im >= ESC_LIMIT);
		end while (!escaped && n < iter_limit);
		in_set = (n == iter_limit);
		r.out_x = p.pixel_x;
		r.out_y = p.pixel_y;
		r.inside_res = in_set;
		r.iteration_count = n;
		r.red = in_set ? p.pixel_x[COLOUR_WIDTH-1:0] : '0;
		r.green = in_set ? p.pixel_y[COLOUR_WIDTH-1:0] : '0;
		r.blue = in_set ? '0 : n[COLOUR_WIDTH-1:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			// cap the log if the block is badly broken
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, got %h", $time, result);
			end else begin
				want = pending_pixels.pop_front();
				check_field("out_x", 32'(want.out_x), 32'(result.out_x));
				check_field("out_y", 32'(want.out_y), 32'(result.out_y));
				check_field("inside_res", 32'(want.inside_res), 32'(result.inside_res));
				check_field("iteration_count", 32'(want.iteration_count),
					32'(result.iteration_count));
				check_field("red", 32'(want.red), 32'(result.red));
				check_field("green", 32'(want.green), 32'(result.green));
				check_field("blue", 32'(want.blue), 32'(result.blue));
			end
		end
	end

	task automatic plot(input logic [COORD_WIDTH-1:0] x, input logic [COORD_WIDTH-1:0] y);
		pixel_t p;
		p.pixel_x = x;
		p.pixel_y = y;
		pixel <= p;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_pixels.push_back(escape_time(p));
	endtask

	task automatic pause_sender(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// wait for every outstanding result, then let the sequencer go idle
	task automatic settle();
		start <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input int ore, input int oim, input bit [STEP_WIDTH-1:0] sre,
			input bit [STEP_WIDTH-1:0] sim, input bit [ITER_WIDTH-1:0] lim);
		logic [CFG_IDX_WIDTH-1:0] regs [5];
		logic [CFG_DATA_WIDTH-1:0] vals [5];
		regs[0] = CFG_ORIGIN_REAL;
		regs[1] = CFG_ORIGIN_IMAG;
		regs[2] = CFG_STEP_REAL;
		regs[3] = CFG_STEP_IMAG;
		regs[4] = CFG_MAX_ITER;
		vals[0] = ore;
		vals[1] = oim;
		vals[2] = {1'b0, sre};
		vals[3] = {1'b0, sim};
		vals[4] = {16'd0, lim};
		settle();
		for (int k = 0; k < 5; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[k];
			cfg_data <= vals[k];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		win_origin_re = ore;
		win_origin_im = oim;
		win_step_re = sre;
		win_step_im = sim;
		iter_limit = lim;
	endtask

	task automatic test_default_window();
		plot(12'd0, 12'd0);
		plot(12'hFFF, 12'hFFF);
		plot(12'hAAA, 12'h555);
		plot(12'h555, 12'hAAA);
		plot(12'd320, 12'd240);
		plot(12'd400, 12'd240);
	endtask

	task automatic test_limit_extremes();
		// c = 0 never escapes, so the limit alone decides
		set_window(0, 0, '0, '0, 16'd1);
		plot(12'd0, 12'd0);
		plot(12'hFFF, 12'hFFF);
		// zero limit still runs one iteration and reports escaped
		set_window(0, 0, '0, '0, 16'd0);
		plot(12'hFFF, 12'h0F0);
		set_window(0, 0, '0, '0, 16'hFFFF);
		plot(12'd123, 12'd45);
	endtask

	task automatic test_saturation();
		// coordinate overflow on both axes, iterate pinned at the rails
		set_window(VAL_MAX, VAL_MIN, STEP_MAX, STEP_MAX, MAX_ITER_RST);
		plot(12'hFFF, 12'hFFF);
		plot(12'd0, 12'd0);
		plot(12'd1, 12'd0);
		set_window(VAL_MIN, VAL_MAX, '0, STEP_MAX, 16'd16);
		plot(12'd7, 12'hFFF);
		plot(12'hFFF, 12'd0);
	endtask

	task automatic test_random_windows();
		bit calm;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase % 4 == 3) begin
				set_window(int'($urandom), int'($urandom),
					STEP_WIDTH'($urandom_range(0, 32'h7FFF_FFFF)),
					STEP_WIDTH'($urandom_range(0, 32'h7FFF_FFFF)),
					ITER_WIDTH'($urandom_range(1, 48)));
			end else begin
				// windows over the interesting part of the set
				set_window(int'($urandom_range(0, 805306368) - 671088640),
					int'($urandom_range(0, 402653184) - 402653184),
					STEP_WIDTH'($urandom_range(0, 300000)),
					STEP_WIDTH'($urandom_range(0, 300000)),
					ITER_WIDTH'($urandom_range(1, 48)));
			end
			calm = 1'b0;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i % 25 == 0)
					calm = ($urandom_range(0, 2) == 0);
				if (i == ITEMS_PER_PHASE / 2 && phase != RANDOM_PHASES - 1)
					settle();
				else if (phase != RANDOM_PHASES - 1 && !calm && $urandom_range(0, 3) == 0)
					pause_sender($urandom_range(1, 7));
				plot(COORD_WIDTH'($urandom_range(0, 4095)),
					COORD_WIDTH'($urandom_range(0, 4095)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		win_origin_re = ORIGIN_REAL_RST;
		win_origin_im = ORIGIN_IMAG_RST;
		win_step_re = STEP_REAL_RST;
		win_step_im = STEP_IMAG_RST;
		iter_limit = MAX_ITER_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_window();
		test_limit_extremes();
		test_saturation();
		test_random_windows();
		settle();

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* mandelbrot_escape_time_pixel_top.f */
hw/rtl/mbrot_pkg.sv
hw/rtl/mbrot_cfg_regs.sv
hw/rtl/mbrot_mul.sv
hw/rtl/mbrot_seq.sv
hw/rtl/mandelbrot_escape_time_pixel_top.sv
tb/sv/tb_mandelbrot_escape_time_pixel_top.sv
